FILE: hdl/ran_pkg.sv
// ---------------------------------------------------------------------------
// ran_pkg: shared types and constants for the rational adder
// Holds the field widths, the default word width and the field maximum.
// ---------------------------------------------------------------------------
package ran_pkg;

	localparam int NUM_BITS = 32;
	localparam int DEN_BITS = 31;
	localparam int WORD_BITS_DEF = 32;
	localparam logic [30:0] FIELD_MAX = 31'h7FFF_FFFF;

endpackage

FILE: hdl/rational_add_normalize_core.sv
// ---------------------------------------------------------------------------
// rational_add_normalize_core: fraction adder with reduction to lowest terms
// Adds a_num/a_den and b_num/b_den and reduces the sum by its gcd.
// ---------------------------------------------------------------------------
// Usage: drive the four operand ports and pulse start while busy is low; the
// beat is taken at that edge and busy rises. When the work ends, done is high
// for exactly one cycle with sum_num, sum_den and overflow; busy falls in the
// same cycle, so a new beat may start on the edge that ends it. The receiver
// cannot stall; sum_num, sum_den and overflow stay until the next done cycle.
// Each Euclid step and each of the five quotients runs on the one shared
// divider, and the three products on the one shared multiplier. Two Euclid
// loops run (each up to about 1.5*WORD_BITS steps), so the time per item is
// data dependent; the Euclid loops set it. A new beat is taken only once busy
// has fallen with done. A bad input goes from the check state straight to the
// output state.
// Reset: arst_n clears the sequencer; no result is pending after reset.
// Overflow: on a bad input (a zero denominator or a field beyond the word) or
// an intermediate outside the signed word, overflow is 1, sum_num and sum_den 0.
// ---------------------------------------------------------------------------
module rational_add_normalize_core
	import ran_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [31:0]  a_num,
	input  logic [30:0]         a_den,
	input  logic signed [31:0]  b_num,
	input  logic [30:0]         b_den,
	output logic                done,
	output logic signed [31:0]  sum_num,
	output logic [30:0]         sum_den,
	output logic                overflow
);

	localparam int W = WORD_BITS;
	localparam int PW = 2 * W + 2;
	localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHK, ST_G1, ST_Q, ST_LCM, ST_SA, ST_SB, ST_MA, ST_MB,
		ST_ADD, ST_G2, ST_RN, ST_RD, ST_OUT
	} state_t;

	state_t        state_q;
	logic [W-1:0]  ga_q, gb_q;
	logic [W-1:0]  da_q, db_q, lcm_q, sa_q, sb_q, smag_q, rn_q;
	logic signed [W:0] na_q, nb_q;
	logic signed [W+1:0] pa_q, pb_q;
	logic          ssgn_q, ovf_q, wait_q;
	logic          dgo;
	logic [W-1:0]  dvd, dvs, quot, rem;
	logic          ddone;
	logic [PW-1:0] prod;
	logic [PW-1:0] mul_a;
	logic [W-1:0]  mul_b;
	logic signed [W+2:0] ssum;
	logic          in_bad;
	logic signed [63:0] wide_a, wide_b;

	ran_divu #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n), .go(dgo), .dividend(dvd), .divisor(dvs),
		.done(ddone), .quot(quot), .rem(rem)
	);

	// Range check of the inputs against the word.
	assign wide_a = 64'(signed'(a_num));
	assign wide_b = 64'(signed'(b_num));
	always_comb begin
		in_bad = 1'b0;
		if (W < 32) begin
			if (wide_a > 64'(signed'({1'b0, WMAX})) ||
			    wide_a < -64'(signed'({1'b0, WMAX})) - 64'sd1 ||
			    wide_b > 64'(signed'({1'b0, WMAX})) ||
			    wide_b < -64'(signed'({1'b0, WMAX})) - 64'sd1 ||
			    64'(a_den) > 64'(WMAX) || 64'(b_den) > 64'(WMAX))
				in_bad = 1'b1;
		end
		if (a_den == '0 || b_den == '0)
			in_bad = 1'b1;
	end

	// One shared multiplier: magnitude times unsigned factor.
	always_comb begin
		mul_a = PW'(lcm_q);
		mul_b = sa_q;
		unique case (state_q)
			ST_LCM:  begin mul_a = PW'(sa_q); mul_b = db_q; end
			ST_MA:   begin mul_a = PW'(na_q < 0 ? -na_q : na_q); mul_b = sa_q; end
			ST_MB:   begin mul_a = PW'(nb_q < 0 ? -nb_q : nb_q); mul_b = sb_q; end
			default: begin mul_a = PW'(lcm_q); mul_b = sa_q; end
		endcase
	end
	assign prod = PW'(mul_a * PW'(mul_b));
	assign ssum = (W+3)'(pa_q) + (W+3)'(pb_q);

	// Divider operand selection per state.
	always_comb begin
		dvd = ga_q;
		dvs = gb_q;
		unique case (state_q)
			ST_Q:    begin dvd = da_q;   dvs = ga_q; end
			ST_SA:   begin dvd = lcm_q;  dvs = da_q; end
			ST_SB:   begin dvd = lcm_q;  dvs = db_q; end
			ST_RN:   begin dvd = smag_q; dvs = ga_q; end
			ST_RD:   begin dvd = lcm_q;  dvs = ga_q; end
			default: begin dvd = ga_q;   dvs = gb_q; end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	// Sequencer: state and registered results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			wait_q   <= 1'b0;
			dgo      <= 1'b0;
			done     <= 1'b0;
			overflow <= 1'b0;
			sum_num  <= '0;
			sum_den  <= '0;
		end else begin
			dgo  <= 1'b0;
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						na_q    <= (W+1)'(signed'(a_num));
						nb_q    <= (W+1)'(signed'(b_num));
						da_q    <= W'(a_den);
						db_q    <= W'(b_den);
						ga_q    <= W'(a_den);
						gb_q    <= W'(b_den);
						ovf_q   <= in_bad;
						wait_q  <= 1'b0;
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					state_q <= ovf_q ? ST_OUT : ST_G1;
				end
				ST_G1, ST_G2: begin
					// Euclid step: (a, b) <- (b, a mod b) until b is zero.
					if (!wait_q) begin
						if (gb_q == '0) begin
							state_q <= (state_q == ST_G1) ? ST_Q : ST_RN;
							dgo     <= 1'b1;
							wait_q  <= 1'b1;
						end else begin
							dgo    <= 1'b1;
							wait_q <= 1'b1;
						end
					end else if (ddone) begin
						ga_q   <= gb_q;
						gb_q   <= rem;
						wait_q <= 1'b0;
					end
				end
				ST_Q: begin
					if (ddone) begin
						sa_q    <= quot;
						wait_q  <= 1'b0;
						state_q <= ST_LCM;
					end
				end
				ST_LCM: begin
					if (prod > PW'(WMAX))
						ovf_q <= 1'b1;
					lcm_q   <= prod[W-1:0];
					state_q <= (prod > PW'(WMAX)) ? ST_OUT : ST_SA;
					dgo     <= !(prod > PW'(WMAX));
					wait_q  <= 1'b1;
				end
				ST_SA: begin
					if (ddone) begin
						sa_q    <= quot;
						state_q <= ST_SB;
						dgo     <= 1'b1;
					end
				end
				ST_SB: begin
					if (ddone) begin
						sb_q    <= quot;
						wait_q  <= 1'b0;
						state_q <= ST_MA;
					end
				end
				ST_MA, ST_MB: begin
					// Magnitude limit: WMAX, or WMAX+1 for a negative operand.
					if (prod > PW'(WMAX) + PW'((state_q == ST_MA) ? na_q < 0 : nb_q < 0))
						ovf_q <= 1'b1;
					if (state_q == ST_MA) begin
						pa_q    <= (na_q < 0) ? -(W+2)'(prod[W:0]) : (W+2)'(prod[W:0]);
						state_q <= ST_MB;
					end else begin
						pb_q    <= (nb_q < 0) ? -(W+2)'(prod[W:0]) : (W+2)'(prod[W:0]);
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					// Sum must lie strictly inside the word (most negative excluded).
					if (ovf_q || ssum > (W+3)'(signed'({1'b0, WMAX})) ||
					    ssum < -(W+3)'(signed'({1'b0, WMAX}))) begin
						ovf_q   <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						ssgn_q  <= ssum < 0;
						smag_q  <= (ssum < 0) ? W'(-ssum) : W'(ssum);
						ga_q    <= (ssum < 0) ? W'(-ssum) : W'(ssum);
						gb_q    <= lcm_q;
						wait_q  <= 1'b0;
						state_q <= ST_G2;
					end
				end
				ST_RN: begin
					if (ddone) begin
						rn_q    <= quot;
						dgo     <= 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					if (ddone) begin
						wait_q  <= 1'b0;
						state_q <= ST_OUT;
						if (smag_q == '0) begin
							rn_q <= '0;
							ga_q <= W'(1);
						end else begin
							ga_q <= quot;
							if (64'(rn_q) > 64'(FIELD_MAX) || 64'(quot) > 64'(FIELD_MAX))
								ovf_q <= 1'b1;
						end
					end
				end
				ST_OUT: begin
					done     <= 1'b1;
					overflow <= ovf_q;
					sum_num  <= ovf_q ? '0 :
					            (ssgn_q ? -32'(rn_q) : 32'(rn_q));
					sum_den  <= ovf_q ? '0 : 31'(ga_q);
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// A result strobe follows the output state exactly.
	a_done_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_OUT)) else $error("done without output state");
	// No beat is taken while work is pending.
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=> (state_q != ST_CHK)) else $error("beat taken while busy");
	// An overflow result carries zero fields.
	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overflow) |-> (sum_num == '0 && sum_den == '0))
		else $error("overflow result not zeroed");
	// A good result never has a zero denominator.
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !overflow) |-> (sum_den != '0)) else $error("zero denominator");

endmodule

FILE: hdl/ran_divu.sv
// ---------------------------------------------------------------------------
// ran_divu: shared restoring divider
// Unsigned division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module ran_divu
	import ran_pkg::*;
#(
	parameter int W = WORD_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         go,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quot,
	output logic [W-1:0] rem
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  d_q;
	logic [W-1:0]  qt_q;
	logic [W:0]    r_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic [W:0]    shifted;
	logic [W:0]    diff;

	// Shift one dividend bit into the partial remainder and try a subtract.
	assign shifted = {r_q[W-1:0], qt_q[W-1]};
	assign diff    = shifted - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W);
				d_q   <= divisor;
				qt_q  <= dividend;
				r_q   <= '0;
			end else if (run_q) begin
				if (diff[W]) begin
					r_q  <= shifted;
					qt_q <= {qt_q[W-2:0], 1'b0};
				end else begin
					r_q  <= diff;
					qt_q <= {qt_q[W-2:0], 1'b1};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	assign quot = qt_q;
	assign rem  = r_q[W-1:0];

endmodule

FILE: bench/rational_add_normalize_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rational_add_normalize_checker: sum predictor and result comparator
// Watches accepted operand beats, works out the reduced sum of each, and
// compares every done beat field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module rational_add_normalize_checker
	import ran_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic signed [31:0]  a_num,
	input  logic [30:0]         a_den,
	input  logic signed [31:0]  b_num,
	input  logic [30:0]         b_den,
	input  logic                done,
	input  logic signed [31:0]  sum_num,
	input  logic [30:0]         sum_den,
	input  logic                overflow,
	output int                  fail_count,
	output int                  pending
);

	typedef struct packed {
		logic signed [31:0] num;
		logic [30:0]        den;
		logic               ovf;
	} sum_t;

	sum_t sum_q[$];

	localparam longint WMAX = (longint'(1) << (WORD_BITS - 1)) - 1;
	localparam longint WMIN = -WMAX - 1;

	function automatic longint unsigned euclid(longint unsigned x, longint unsigned y);
		longint unsigned t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	// Signed value times positive factor, staying inside the word.
	function automatic bit scale_fits(longint v, longint unsigned f, output longint r);
		longint unsigned m, lim;
		m = (v < 0) ? -v : v;
		lim = (v < 0) ? longint'(WMAX) + 1 : WMAX;
		if (f != 0 && m > lim / f)
			return 0;
		r = (v < 0) ? -longint'(m * f) : longint'(m * f);
		return 1;
	endfunction

	function automatic sum_t predict_sum(logic signed [31:0] an, logic [30:0] ad,
			logic signed [31:0] bn, logic [30:0] bd);
		sum_t bad, res;
		longint na, nb, pa, pb, s;
		longint unsigned g, q, lcm, mag, rn, rd;
		bad = '{num: '0, den: '0, ovf: 1'b1};
		na = an;
		nb = bn;
		if (na < WMIN || na > WMAX || nb < WMIN || nb > WMAX)
			return bad;
		if (ad == 0 || bd == 0 || ad > WMAX || bd > WMAX)
			return bad;
		g = euclid(ad, bd);
		q = ad / g;
		if (q > longint'(WMAX) / bd)
			return bad;
		lcm = q * bd;
		if (!scale_fits(na, lcm / ad, pa) || !scale_fits(nb, lcm / bd, pb))
			return bad;
		s = pa + pb;
		if (s > WMAX || s < WMIN || s == WMIN)
			return bad;
		mag = (s < 0) ? -s : s;
		g = euclid(mag, lcm);
		rn = mag / g;
		rd = lcm / g;
		if (mag == 0) begin
			rn = 0;
			rd = 1;
		end
		if (rn > FIELD_MAX || rd > FIELD_MAX)
			return bad;
		res.num = (s < 0) ? -rn[31:0] : rn[31:0];
		res.den = rd[30:0];
		res.ovf = 1'b0;
		return res;
	endfunction

	// Predict on every accepted operand beat and check every done beat.
	always @(posedge clk or negedge arst_n) begin
		sum_t exp_sum;
		int   errs;
		if (!arst_n) begin
			fail_count <= 0;
			pending    <= 0;
			sum_q.delete();
		end else begin
			errs = 0;
			if (start && !busy)
				sum_q = {sum_q, predict_sum(a_num, a_den, b_num, b_den)};
			if (done) begin
				if (sum_q.size() == 0) begin
					$error("Result beat with no prediction waiting");
					errs = errs + 1;
				end else begin
					exp_sum = sum_q.pop_front();
					if (overflow !== exp_sum.ovf) begin
						$error("overflow: expected %0d, got %0d", exp_sum.ovf, overflow);
						errs = errs + 1;
					end
					if (sum_num !== exp_sum.num) begin
						$error("sum_num: expected %0d, got %0d", exp_sum.num, sum_num);
						errs = errs + 1;
					end
					if (sum_den !== exp_sum.den) begin
						$error("sum_den: expected %0d, got %0d", exp_sum.den, sum_den);
						errs = errs + 1;
					end
				end
			end
			fail_count <= fail_count + errs;
			pending    <= sum_q.size();
		end
	end

endmodule

FILE: bench/rational_add_normalize_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rational_add_normalize_core_tb: regression bench for the fraction adder
// Drives directed and random operand beats with random gaps; a checker
// predicts each reduced sum and counts mismatches for the verdict.
// ---------------------------------------------------------------------------
module rational_add_normalize_core_tb
	import ran_pkg::*;
();

	localparam int RANDOM_BEATS = 1080;
	localparam int STALL_LIMIT = 20000;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] a_num;
	logic [30:0]        a_den;
	logic signed [31:0] b_num;
	logic [30:0]        b_den;
	logic               done;
	logic signed [31:0] sum_num;
	logic [30:0]        sum_den;
	logic               overflow;
	int                 fail_count;
	int                 pending;
	int                 idle_cycles = 0;

	rational_add_normalize_core dut (.*);

	rational_add_normalize_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: ends the run when no beat moves for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Sends one operand beat after a random gap, holding start until taken.
	// Start stays high after the taking edge; the next call or the caller drops it.
	task automatic send_beat(logic signed [31:0] an, logic [30:0] ad,
			logic signed [31:0] bn, logic [30:0] bd);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		a_num <= an;
		a_den <= ad;
		b_num <= bn;
		b_den <= bd;
		do @(posedge clk); while (busy);
	endtask

	function automatic logic [30:0] pick_den();
		case ($urandom_range(0, 4))
			0: return 31'($urandom_range(0, 16));
			1: return 31'($urandom_range(1, 1000));
			2: return 31'($urandom_range(1, 65536));
			3: return FIELD_MAX - 31'($urandom_range(0, 3));
			default: return 31'($urandom);
		endcase
	endfunction

	function automatic logic signed [31:0] pick_num();
		case ($urandom_range(0, 4))
			0: return 32'($urandom_range(0, 40)) - 32'sd20;
			1: return 32'($urandom_range(0, 20000)) - 32'sd10000;
			2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return 32'($urandom);
		endcase
	endfunction

	initial begin
		logic signed [31:0] n;
		start = 1'b0;
		a_num = '0;
		a_den = '0;
		b_num = '0;
		b_den = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, zero sums, zero denominators, most negative sum.
		send_beat(32'sd1, 31'd2, 32'sd1, 31'd3);
		send_beat(32'sd1, 31'd2, -32'sd1, 31'd2);
		send_beat(32'sd0, 31'd1, 32'sd0, 31'd1);
		send_beat(32'sd3, 31'd0, 32'sd1, 31'd1);
		send_beat(32'sd3, 31'd1, 32'sd1, 31'd0);
		send_beat(32'sh7FFF_FFFF, 31'd1, 32'sd1, 31'd1);
		send_beat(32'sh8000_0000, 31'd1, 32'sd0, 31'd1);
		send_beat(32'sh8000_0001, 31'd1, -32'sd1, 31'd1);
		send_beat(32'sh8000_0001, 31'd1, 32'sd1, 31'd1);
		send_beat(32'sh7FFF_FFFF, FIELD_MAX, 32'sh8000_0001, FIELD_MAX);
		send_beat(32'sh7FFF_FFFF, FIELD_MAX, 32'sd1, FIELD_MAX);
		send_beat(32'sd1, FIELD_MAX, 32'sd1, FIELD_MAX - 31'd1);
		send_beat(32'sd6, 31'd4, 32'sd10, 31'd4);
		send_beat(-32'sd6, 31'd4, -32'sd10, 31'd4);
		send_beat(32'sd5, 31'd65536, 32'sd7, 31'd32768);
		send_beat(32'sd1, 31'd46341, 32'sd1, 31'd46337);
		send_beat(32'shAAAA_AAAA, 31'h5555_5555, 32'sh5555_5555, 31'h2AAA_AAAA);

		// Let everything drain before the random part.
		start <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);

		for (int i = 0; i < RANDOM_BEATS; i++) begin
			n = pick_num();
			if (i % 7 == 0)
				send_beat(n, 31'd1 << $urandom_range(0, 12), pick_num(),
					31'd1 << $urandom_range(0, 12));
			else
				send_beat(n, pick_den(), pick_num(), pick_den());
			if (i == RANDOM_BEATS / 2) begin
				start <= 1'b0;
				@(posedge clk);
				wait (pending == 0);
				@(posedge clk);
			end
		end

		start <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
